/* design/bfc_pkg.sv */
// Shared types, constants and codes for the box frustum classifier.
`default_nettype none
package bfc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int NUM_COEFS  = 4;
  localparam int PLANE_W    = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

  localparam int COEF_W  = 32;
  localparam int COORD_W = 24;
  localparam int PROD_W  = COEF_W + COORD_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam int IDX_W     = 3;
  localparam int CIDX_W    = 2;
  localparam int VERDICT_W = 2;
  localparam int STEP_W    = 3;

  // Multiply steps per plane: A, B and C each against both corners.
  localparam logic [STEP_W-1:0] LAST_MUL_STEP = 3'd5;
  localparam logic [STEP_W-1:0] LAST_STEP     = 3'd6;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_BOX  = 1'b1;

  localparam logic [CIDX_W-1:0] COEF_A = 2'd0;
  localparam logic [CIDX_W-1:0] COEF_B = 2'd1;
  localparam logic [CIDX_W-1:0] COEF_C = 2'd2;
  localparam logic [CIDX_W-1:0] COEF_D = 2'd3;

  localparam logic [VERDICT_W-1:0] VERDICT_INSIDE    = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_OUTSIDE   = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_INTERSECT = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [NUM_COEFS-1:0][COEF_W-1:0] row_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_MUL,
    S_TEST
  } state_t;

  typedef struct packed {
    logic              load_box;
    logic              init;
    logic              mul_en;
    logic              save;
    logic              acc;
    logic [CIDX_W-1:0] sel;
    logic              side;
  } mac_ctrl_t;

  typedef struct packed {
    logic hi_neg;
    logic lo_neg;
  } mac_stat_t;

endpackage
`default_nettype wire

/* design/bfc_plane_mem.sv */
// Plane coefficient store: one row of four coefficients per plane.
`default_nettype none
module bfc_plane_mem (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [bfc_pkg::PLANE_W-1:0] wr_plane,
  input  wire logic [bfc_pkg::CIDX_W-1:0]  wr_coef,
  input  wire logic [bfc_pkg::COEF_W-1:0]  wr_data,
  input  wire logic                        rd_en,
  input  wire logic [bfc_pkg::PLANE_W-1:0] rd_plane,
  output bfc_pkg::row_t                    rd_row
);
  import bfc_pkg::*;

  row_t mem [NUM_PLANES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_plane][wr_coef] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row <= mem[rd_plane];
    end
  end

endmodule
`default_nettype wire

/* design/bfc_mac.sv */
// Shared multiplier with min/max accumulators for the plane value bounds.
`default_nettype none
module bfc_mac (
  input  wire logic               clk,
  input  wire bfc_pkg::mac_ctrl_t ctrl,
  input  wire bfc_pkg::coord_t    first_x,
  input  wire bfc_pkg::coord_t    first_y,
  input  wire bfc_pkg::coord_t    first_z,
  input  wire bfc_pkg::coord_t    second_x,
  input  wire bfc_pkg::coord_t    second_y,
  input  wire bfc_pkg::coord_t    second_z,
  input  wire bfc_pkg::row_t      row,
  output bfc_pkg::mac_stat_t      stat
);
  import bfc_pkg::*;

  coord_t lo_c [3];
  coord_t hi_c [3];

  logic signed [COEF_W-1:0] coef;
  logic signed [COEF_W-1:0] coef_d;
  coord_t                   coord;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prev;
  logic signed [PROD_W-1:0] big;
  logic signed [PROD_W-1:0] little;
  logic signed [ACC_W-1:0]  acc_hi;
  logic signed [ACC_W-1:0]  acc_lo;

  always_ff @(posedge clk) begin
    if (ctrl.load_box) begin
      lo_c[0] <= first_x;
      lo_c[1] <= first_y;
      lo_c[2] <= first_z;
      hi_c[0] <= second_x;
      hi_c[1] <= second_y;
      hi_c[2] <= second_z;
    end
  end

  always_comb begin
    coef   = $signed(row[ctrl.sel]);
    coef_d = $signed(row[COEF_D]);
    unique case (ctrl.sel)
      COEF_A:  coord = ctrl.side ? hi_c[0] : lo_c[0];
      COEF_B:  coord = ctrl.side ? hi_c[1] : lo_c[1];
      COEF_C:  coord = ctrl.side ? hi_c[2] : lo_c[2];
      default: coord = '0;
    endcase
  end

  // The plane value is separable per axis, so its largest and smallest value
  // over the eight corners are the sums of the per-axis larger and smaller terms.
  always_comb begin
    if (prev > prod) begin
      big    = prev;
      little = prod;
    end else begin
      big    = prod;
      little = prev;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= coef * coord;
    end
    if (ctrl.save) begin
      prev <= prod;
    end
    if (ctrl.init) begin
      acc_hi <= {{(ACC_W-COEF_W){coef_d[COEF_W-1]}}, coef_d};
      acc_lo <= {{(ACC_W-COEF_W){coef_d[COEF_W-1]}}, coef_d};
    end else if (ctrl.acc) begin
      acc_hi <= acc_hi + {{(ACC_W-PROD_W){big[PROD_W-1]}}, big};
      acc_lo <= acc_lo + {{(ACC_W-PROD_W){little[PROD_W-1]}}, little};
    end
  end

  assign stat.hi_neg = acc_hi[ACC_W-1];
  assign stat.lo_neg = acc_lo[ACC_W-1];

endmodule
`default_nettype wire

/* design/bfc_seq.sv */
// Sequencer: walks the planes and multiply steps and holds the verdict register.
`default_nettype none
module bfc_seq (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  input  wire logic                          op,
  output logic                               s_tready,
  output logic                               rd_en,
  output logic [bfc_pkg::PLANE_W-1:0]        rd_plane,
  output bfc_pkg::mac_ctrl_t                 ctrl,
  input  wire bfc_pkg::mac_stat_t            stat,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [bfc_pkg::VERDICT_W-1:0]      verdict
);
  import bfc_pkg::*;

  state_t               state, state_next;
  logic [PLANE_W-1:0]   plane, plane_next;
  logic [STEP_W-1:0]    step, step_next;
  logic                 any_out, any_out_next;
  logic                 any_split, any_split_next;
  logic                 m_valid_next;
  logic [VERDICT_W-1:0] verdict_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= m_valid_next;
    end
    plane     <= plane_next;
    step      <= step_next;
    any_out   <= any_out_next;
    any_split <= any_split_next;
    verdict   <= verdict_next;
  end

  always_comb begin
    state_next     = state;
    plane_next     = plane;
    step_next      = step;
    any_out_next   = any_out;
    any_split_next = any_split;
    m_valid_next   = m_tvalid && !m_tready;
    verdict_next   = verdict;
    s_tready       = 1'b0;
    rd_en          = 1'b0;
    rd_plane       = plane;
    ctrl           = '0;
    ctrl.sel       = step[2:1];
    ctrl.side      = step[0];

    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid && op == OP_BOX) begin
          ctrl.load_box  = 1'b1;
          plane_next     = '0;
          any_out_next   = 1'b0;
          any_split_next = 1'b0;
          state_next     = S_FETCH;
        end
      end
      S_FETCH: begin
        rd_en      = 1'b1;
        step_next  = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        // The product register holds the product of the previous step: the first of each
        // pair of products is parked, the second is folded into the bounds.
        ctrl.init   = (step == '0);
        ctrl.mul_en = (step <= LAST_MUL_STEP);
        ctrl.save   = step[0];
        ctrl.acc    = !step[0] && (step != '0);
        if (step == LAST_STEP) begin
          state_next = S_TEST;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_TEST: begin
        if (stat.hi_neg) begin
          any_out_next = 1'b1;
        end else if (stat.lo_neg) begin
          any_split_next = 1'b1;
        end
        if (plane != PLANE_W'(NUM_PLANES - 1)) begin
          plane_next = plane + 1'b1;
          state_next = S_FETCH;
        end else if (!m_tvalid || m_tready) begin
          m_valid_next = 1'b1;
          if (any_out_next) begin
            verdict_next = VERDICT_OUTSIDE;
          end else if (any_split_next) begin
            verdict_next = VERDICT_INTERSECT;
          end else begin
            verdict_next = VERDICT_INSIDE;
          end
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* design/box_frustum_classifier.sv */
// Top level of the box frustum classifier.
`default_nettype none
// Classifies an axis-aligned box against six stored clipping planes. A load
// item (tuser 0) writes one plane coefficient; a box item (tuser 1) is swept
// plane by plane through one shared 32x24 multiplier that forms the six
// coefficient-coordinate products of a plane, keeping the largest and smallest
// plane value over the eight corners. Each plane passes through a row read,
// seven multiply and accumulate steps and a test. The verdict of a box is
// registered at the end of the last plane test, and the next item can be taken
// in the cycle in which that verdict is first presented on the output.
// If the previous verdict is still waiting on the output, the last plane
// test holds until that verdict is taken. The block takes no item while a
// box is being classified. All planes must be loaded before the first box.
module box_frustum_classifier (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [2:0] plane_index, [4:3] coef_index, [36:5] coef_value, [60:37] first_x,
  // [84:61] first_y, [108:85] first_z, [132:109] second_x,
  // [156:133] second_y, [180:157] second_z, [183:181] zero
  input  wire logic [183:0] s_tdata,
  // [0] op
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [1:0] verdict, [7:2] zero
  output logic [7:0]        m_tdata
);
  import bfc_pkg::*;

  logic [IDX_W-1:0]     plane_index;
  logic [CIDX_W-1:0]    coef_index;
  logic [COEF_W-1:0]    coef_value;
  logic                 op;
  logic                 wr_en;
  logic                 rd_en;
  logic [PLANE_W-1:0]   rd_plane;
  row_t                 row;
  mac_ctrl_t            ctrl;
  mac_stat_t            stat;
  logic [VERDICT_W-1:0] verdict;

  assign op          = s_tuser[0];
  assign plane_index = s_tdata[2:0];
  assign coef_index  = s_tdata[4:3];
  assign coef_value  = s_tdata[36:5];

  assign wr_en = s_tvalid && s_tready && op == OP_LOAD
                 && int'(plane_index) < NUM_PLANES;

  bfc_plane_mem u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_plane (PLANE_W'(plane_index)),
    .wr_coef  (coef_index),
    .wr_data  (coef_value),
    .rd_en    (rd_en),
    .rd_plane (rd_plane),
    .rd_row   (row)
  );

  bfc_mac u_mac (
    .clk      (clk),
    .ctrl     (ctrl),
    .first_x  (s_tdata[60:37]),
    .first_y  (s_tdata[84:61]),
    .first_z  (s_tdata[108:85]),
    .second_x (s_tdata[132:109]),
    .second_y (s_tdata[156:133]),
    .second_z (s_tdata[180:157]),
    .row      (row),
    .stat     (stat)
  );

  bfc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (op),
    .s_tready (s_tready),
    .rd_en    (rd_en),
    .rd_plane (rd_plane),
    .ctrl     (ctrl),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .verdict  (verdict)
  );

  assign m_tdata = {6'b0, verdict};

  // A box item occupies the block: no further item is taken the next cycle.
  a_box_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && op == OP_BOX |=> !s_tready)
    else $error("item accepted right after a box item");

  // A load item finishes in its own cycle.
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && op == OP_LOAD |=> s_tready)
    else $error("load item stalled the block");

  // A verdict only ever carries one of the three defined codes.
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (verdict == VERDICT_INSIDE || verdict == VERDICT_OUTSIDE
                  || verdict == VERDICT_INTERSECT))
    else $error("undefined verdict code");

  // The control bits never ask the accumulator to load and add at once, nor park a product while adding.
  a_ctrl_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.init && ctrl.acc) && !(ctrl.save && ctrl.acc))
    else $error("conflicting accumulator controls");

endmodule
`default_nettype wire

/* sim/box_frustum_classifier_tb.sv */
// Self-checking testbench for the box frustum classifier: plane loads, box items and verdicts.
`default_nettype none
module box_frustum_classifier_tb;
  import bfc_pkg::*;

  localparam int TOTAL_ITEMS   = 1950;
  localparam int QUIET_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 300;
  localparam int UNIT          = 256;         // 1.0 in corner coordinates
  localparam int ONE_COEF      = 65536;       // 1.0 for A, B and C
  localparam int COORD_MIN     = -(1 << 23);
  localparam int COORD_MAX     = (1 << 23) - 1;
  localparam int COEF_MAX      = 32'h7fff_ffff;
  localparam int COEF_MIN      = 32'h8000_0000;

  typedef enum int {
    SCENE_BOX,
    SCENE_TILTED,
    SCENE_NOISE
  } scene_kind_t;

  // Packed in the same order as s_tdata, the last member in the lowest bits.
  typedef struct packed {
    logic [2:0]          zero;
    coord_t              second_z;
    coord_t              second_y;
    coord_t              second_x;
    coord_t              first_z;
    coord_t              first_y;
    coord_t              first_x;
    logic signed [31:0]  coef_value;
    logic [CIDX_W-1:0]   coef_index;
    logic [IDX_W-1:0]    plane_index;
  } box_item_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [183:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [7:0]   m_tdata;

  logic signed [COEF_W-1:0] plane_coef [NUM_PLANES][NUM_COEFS];
  logic [VERDICT_W-1:0]     verdict_q [$];
  logic [VERDICT_W-1:0]     exp_verdict;

  int  errors = 0;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  int  hold_requests = 0;
  int  holds_started = 0;
  int  rx_hold_left = 0;
  int  rx_wait = 0;

  box_frustum_classifier i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [VERDICT_W-1:0] classify_box(input box_item_t it);
    longint xs [2];
    longint ys [2];
    longint zs [2];
    longint plane_value;
    int     inside_count;
    bit     any_outside;
    bit     any_split;
    xs[0] = longint'(it.first_x);
    ys[0] = longint'(it.first_y);
    zs[0] = longint'(it.first_z);
    xs[1] = longint'(it.second_x);
    ys[1] = longint'(it.second_y);
    zs[1] = longint'(it.second_z);
    any_outside = 1'b0;
    any_split   = 1'b0;
    for (int p = 0; p < NUM_PLANES; p++) begin
      inside_count = 0;
      for (int k = 0; k < 8; k++) begin
        plane_value = longint'(plane_coef[p][COEF_A]) * xs[k & 1]
                    + longint'(plane_coef[p][COEF_B]) * ys[(k >> 1) & 1]
                    + longint'(plane_coef[p][COEF_C]) * zs[(k >> 2) & 1]
                    + longint'(plane_coef[p][COEF_D]);
        if (plane_value >= 0) inside_count++;
      end
      if (inside_count == 0) any_outside = 1'b1;
      else if (inside_count < 8) any_split = 1'b1;
    end
    if (any_outside) return VERDICT_OUTSIDE;
    if (any_split) return VERDICT_INTERSECT;
    return VERDICT_INSIDE;
  endfunction

  // Fields that an item does not use, apart from the zero bits, still carry random bits.
  function automatic box_item_t random_fill();
    box_item_t it;
    it.zero        = '0;
    it.plane_index = 3'($urandom);
    it.coef_index  = 2'($urandom);
    it.coef_value  = $urandom;
    it.first_x     = 24'($urandom);
    it.first_y     = 24'($urandom);
    it.first_z     = 24'($urandom);
    it.second_x    = 24'($urandom);
    it.second_y    = 24'($urandom);
    it.second_z    = 24'($urandom);
    return it;
  endfunction

  function automatic box_item_t make_load(input int plane, input int coef_sel, input int value);
    box_item_t it;
    it = random_fill();
    it.plane_index = 3'(plane);
    it.coef_index  = 2'(coef_sel);
    it.coef_value  = value;
    return it;
  endfunction

  function automatic box_item_t make_box(input int x0, input int y0, input int z0,
                                         input int x1, input int y1, input int z1);
    box_item_t it;
    it = random_fill();
    it.first_x  = 24'(x0);
    it.first_y  = 24'(y0);
    it.first_z  = 24'(z0);
    it.second_x = 24'(x1);
    it.second_y = 24'(y1);
    it.second_z = 24'(z1);
    return it;
  endfunction

  // A box near the origin, sized to land on either side of the planes of a scene.
  function automatic box_item_t scene_box();
    int lo [3];
    int hi [3];
    int mid;
    int half;
    int tmp;
    for (int a = 0; a < 3; a++) begin
      mid  = int'($urandom_range(0, 51200)) - 25600;
      half = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, UNIT))
                                         : int'($urandom_range(0, 10240));
      lo[a] = mid - half;
      hi[a] = mid + half;
      if ($urandom_range(0, 1) == 1) begin
        tmp   = lo[a];
        lo[a] = hi[a];
        hi[a] = tmp;
      end
    end
    return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endfunction

  function automatic box_item_t noise_box();
    return make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic send_item(input logic op, input box_item_t it);
    int gap;
    gap = tx_idle_on ? int'($urandom_range(0, 11)) : 0;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= it;
    do @(posedge clk); while (!s_tready);
    if (op == OP_BOX) begin
      verdict_q.push_back(classify_box(it));
      items_sent++;
    end else if (it.plane_index < NUM_PLANES) begin
      plane_coef[it.plane_index][it.coef_index] = it.coef_value;
      items_sent++;
    end
  endtask

  task automatic send_ignored_load();
    send_item(OP_LOAD, make_load($urandom_range(NUM_PLANES, 7), $urandom_range(0, 3), $urandom));
  endtask

  task automatic wait_for_verdicts();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // Writes every coefficient of every plane in a random order. A box scene
  // pairs one plane per half space of each axis; a fixed extent gives an
  // exact cube of that half width.
  task automatic load_scene(input scene_kind_t kind, input int extent);
    int coefs [NUM_PLANES * NUM_COEFS];
    int order [NUM_PLANES * NUM_COEFS];
    int j;
    int tmp;
    int axis;
    int sgn;
    for (int p = 0; p < NUM_PLANES; p++) begin
      axis = p / 2;
      sgn  = (p % 2 == 0) ? -1 : 1;
      for (int c = 0; c < NUM_COEFS; c++) begin
        case (kind)
          SCENE_BOX: begin
            if (c == COEF_D)
              coefs[p * NUM_COEFS + c] = (extent > 0 ? extent : int'($urandom_range(1, 100))) << 24;
            else if (c == axis)
              coefs[p * NUM_COEFS + c] = sgn * ONE_COEF;
            else
              coefs[p * NUM_COEFS + c] = (extent > 0) ? 0 : int'($urandom_range(0, 8192)) - 4096;
          end
          SCENE_TILTED: begin
            if (c == COEF_D)
              coefs[p * NUM_COEFS + c] = (int'($urandom_range(0, 200)) - 100) * (1 << 24)
                                       + int'($urandom_range(0, (1 << 24) - 1));
            else
              coefs[p * NUM_COEFS + c] = int'($urandom_range(0, 2 * ONE_COEF)) - ONE_COEF;
          end
          default: coefs[p * NUM_COEFS + c] = $urandom;
        endcase
      end
    end
    for (int i = 0; i < NUM_PLANES * NUM_COEFS; i++) order[i] = i;
    for (int i = NUM_PLANES * NUM_COEFS - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < NUM_PLANES * NUM_COEFS; i++) begin
      if ($urandom_range(0, 15) == 0) send_ignored_load();
      send_item(OP_LOAD, make_load(order[i] / NUM_COEFS, order[i] % NUM_COEFS, coefs[order[i]]));
    end
  endtask

  task automatic test_directed();
    load_scene(SCENE_BOX, 16);
    // Loads beyond the last plane must leave the store alone.
    send_item(OP_LOAD, make_load(NUM_PLANES, COEF_D, COEF_MIN));
    send_item(OP_LOAD, make_load(7, COEF_A, COEF_MIN));
    send_item(OP_BOX, make_box(-UNIT, -UNIT, -UNIT, UNIT, UNIT, UNIT));
    send_item(OP_BOX, make_box(UNIT, UNIT, UNIT, -UNIT, -UNIT, -UNIT));
    send_item(OP_BOX, make_box(0, 0, 0, 0, 0, 0));
    // A corner exactly on a plane counts as inside; one step past it does not.
    send_item(OP_BOX, make_box(16 * UNIT, 0, 0, 16 * UNIT, 0, 0));
    send_item(OP_BOX, make_box(16 * UNIT + 1, 0, 0, 16 * UNIT + 1, 0, 0));
    send_item(OP_BOX, make_box(20 * UNIT, -UNIT, -UNIT, 30 * UNIT, UNIT, UNIT));
    send_item(OP_BOX, make_box(10 * UNIT, -UNIT, -UNIT, 20 * UNIT, UNIT, UNIT));
    send_item(OP_BOX, make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(OP_BOX, make_box(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(OP_LOAD, make_load(0, COEF_A, COEF_MAX));
    send_item(OP_LOAD, make_load(0, COEF_B, COEF_MIN));
    send_item(OP_LOAD, make_load(0, COEF_C, COEF_MAX));
    send_item(OP_LOAD, make_load(0, COEF_D, COEF_MIN));
    send_item(OP_BOX, make_box(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    send_item(OP_BOX, make_box(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX));
    send_item(OP_LOAD, make_load(0, COEF_D, COEF_MAX));
    send_item(OP_BOX, make_box(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
  endtask

  // The receiver stops for a long stretch while boxes keep coming, so the
  // block fills up and holds off its input.
  task automatic test_output_backpressure();
    tx_idle_on = 1'b0;
    load_scene(SCENE_BOX, 0);
    @(negedge clk);
    hold_requests++;
    repeat (12) send_item(OP_BOX, scene_box());
    tx_idle_on = 1'b1;
  endtask

  task automatic test_input_pause();
    load_scene(SCENE_TILTED, 0);
    repeat (8) send_item(OP_BOX, scene_box());
    wait_for_verdicts();
    send_item(OP_LOAD, make_load($urandom_range(0, NUM_PLANES - 1), COEF_D, 0));
    repeat (8) send_item(OP_BOX, scene_box());
  endtask

  task automatic test_random_scenes();
    int draw;
    int box_count;
    while (items_sent < TOTAL_ITEMS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      draw = $urandom_range(0, 9);
      load_scene(draw < 5 ? SCENE_BOX : (draw < 9 ? SCENE_TILTED : SCENE_NOISE), 0);
      box_count = $urandom_range(10, 40);
      repeat (box_count) begin
        draw = $urandom_range(0, 99);
        if (draw < 4)
          send_item(OP_LOAD, make_load($urandom_range(0, NUM_PLANES - 1), COEF_D,
                                       (int'($urandom_range(0, 200)) - 100) * (1 << 24)));
        else if (draw < 6)
          send_ignored_load();
        else if (draw < 18)
          send_item(OP_BOX, noise_box());
        else
          send_item(OP_BOX, scene_box());
      end
    end
  endtask

  // Receiver: draws a wait after each verdict and serves hold requests.
  always begin
    @(posedge clk);
    if (m_tvalid && m_tready) rx_wait = rx_idle_on ? int'($urandom_range(0, 11)) : 0;
    if (hold_requests != holds_started) begin
      holds_started = hold_requests;
      rx_hold_left  = HOLD_CYCLES;
    end
    @(negedge clk);
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: verdict with none pending, expected nothing, actual %0d", $time, m_tdata);
        errors++;
      end else begin
        exp_verdict = verdict_q.pop_front();
        if (m_tdata !== {6'b0, exp_verdict}) begin
          $display("%0t: verdict mismatch, expected %0d, actual %0d", $time, exp_verdict, m_tdata);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_output_backpressure();
    test_input_pause();
    test_random_scenes();
    wait_for_verdicts();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
